// ----- hw/rtl/rfrx_pkg.sv -----
// ----------------------------------------------------------------------------
// rfrx_pkg
// Shared types and constants of the radio frame receive parser: parse modes,
// frame characters, length limit and the state and result records.
// ----------------------------------------------------------------------------
package rfrx_pkg;

   localparam logic [7:0]  CHAR_R       = 8'h52;
   localparam logic [7:0]  CHAR_T       = 8'h54;
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [15:0] HDR_BN       = 16'h424E;
   localparam logic [15:0] MAX_PAYLOAD  = 16'd128;
   localparam logic [23:0] PEER_RESET   = 24'h393939;
   localparam logic [7:0]  STRENGTH_MAX = 8'd199;

   localparam logic KIND_PAYLOAD  = 1'b0;
   localparam logic KIND_STRENGTH = 1'b1;

   typedef enum logic [2:0] {
      MODE_HUNT     = 3'd0,
      MODE_HEADER   = 3'd1,
      MODE_ADDR     = 3'd2,
      MODE_LENGTH   = 3'd3,
      MODE_PAYLOAD  = 3'd4,
      MODE_FOOTER   = 3'd5,
      MODE_STRENGTH = 3'd6
   } parse_mode_type;

   typedef struct packed {
      parse_mode_type mode;
      logic           direct_link;
      logic [1:0]     field_count;
      logic [23:0]    shift_chars;
      logic [15:0]    bytes_left;
      logic [7:0]     strength_accum;
   } parser_state_type;

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [7:0] value;
      logic       last_byte;
   } parser_result_type;

endpackage

// ----- hw/rtl/radio_frame_rx_parser.sv -----
// ----------------------------------------------------------------------------
// radio_frame_rx_parser
// Deframes serial bytes from a radio modem into payload bytes and signal
// strength updates.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one modem byte per transaction (req_rx_byte).
//   rsp_* carries one result per transaction: rsp_kind 0 is a payload byte
//   with rsp_last_byte on the final byte of a frame, rsp_kind 1 is a signal
//   strength value 0 to 199 in rsp_value.
//   csr_* writes the expected peer address, three ASCII characters with the
//   first in bits 23..16; csr_ready is always high. Write it only when idle.
// Timing:
//   A byte is parsed in the cycle it is accepted; its result, if any, is
//   valid on rsp_* in the next cycle. One byte per cycle is accepted, set by
//   the single result register: req_ready is high while that register is
//   empty or is being emptied in the same cycle.
//   When the receiver stalls with a result pending, req_ready drops until it
//   is taken.
// Reset:
//   Synchronous reset returns to hunting for a frame start, clears any
//   pending result and sets the peer address to "999".
// ----------------------------------------------------------------------------
module radio_frame_rx_parser import rfrx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_value,
   output logic        rsp_last_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_peer_addr_ascii
);

   parser_state_type  state_ff, state_in, state_step;
   parser_result_type step_result;
   logic [23:0]       peer_addr_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff;
   logic [7:0]        rsp_value_ff;
   logic              rsp_last_ff;
   logic              req_accept;

   rfrx_next u_next (
      .cur_state  (state_ff),
      .rx_byte    (req_rx_byte),
      .peer_addr  (peer_addr_ff),
      .next_state (state_step),
      .result     (step_result)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_accept) begin
         state_in     = state_step;
         rsp_valid_in = step_result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         peer_addr_ff <= PEER_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            peer_addr_ff <= csr_peer_addr_ascii;
         end
      end
   end

   // result payload, loaded only with a new result transaction
   always_ff @(posedge clock) begin
      if (req_accept && step_result.valid) begin
         rsp_kind_ff  <= step_result.kind;
         rsp_value_ff <= step_result.value;
         rsp_last_ff  <= step_result.last_byte;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_last_byte = rsp_last_ff;

`ifndef SYNTHESIS
   a_payload_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == MODE_PAYLOAD |->
         state_ff.bytes_left != 16'd0 && state_ff.bytes_left <= MAX_PAYLOAD)
      else $error("payload count out of range");

   a_payload_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && state_ff.mode == MODE_PAYLOAD |=> rsp_valid_ff && !rsp_kind_ff)
      else $error("payload byte produced no result");

   a_last_goes_footer: assert property (@(posedge clock) disable iff (reset)
      req_accept && state_ff.mode == MODE_PAYLOAD && state_ff.bytes_left == 16'd1
         |=> state_ff.mode == MODE_FOOTER && rsp_last_ff)
      else $error("last payload byte did not end the payload");

   a_strength_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_STRENGTH |->
         rsp_value_ff <= STRENGTH_MAX && !rsp_last_ff)
      else $error("bad strength result");
`endif

endmodule

// ----- hw/rtl/rfrx_next.sv -----
// ----------------------------------------------------------------------------
// rfrx_next
// Next-state and result logic of the parser for one received byte.
// ----------------------------------------------------------------------------
module rfrx_next import rfrx_pkg::*; (
   input  parser_state_type  cur_state,
   input  logic [7:0]        rx_byte,
   input  logic [23:0]       peer_addr,
   output parser_state_type  next_state,
   output parser_result_type result
);

   logic [7:0]  digit;
   logic [23:0] shifted;
   logic [1:0]  count_inc;
   logic [15:0] length_acc;
   logic [7:0]  strength_acc;

   assign digit        = rx_byte - CHAR_ZERO;
   assign shifted      = {cur_state.shift_chars[15:0], rx_byte};
   assign count_inc    = cur_state.field_count + 2'd1;
   // times ten as two shifts and an add, then add the raw digit
   assign length_acc   = (cur_state.bytes_left << 3) + (cur_state.bytes_left << 1)
                         + {8'd0, rx_byte} - {8'd0, CHAR_ZERO};
   assign strength_acc = (cur_state.strength_accum << 3)
                         + (cur_state.strength_accum << 1) + digit;

   always_comb begin
      next_state       = cur_state;
      result           = '0;
      result.kind      = KIND_PAYLOAD;
      case (cur_state.mode)
         MODE_HEADER: begin
            next_state.shift_chars = shifted;
            next_state.field_count = count_inc;
            if (count_inc == 2'd2) begin
               if (shifted == {8'd0, HDR_BN}) begin
                  next_state.mode        = MODE_ADDR;
                  next_state.field_count = 2'd0;
                  next_state.shift_chars = '0;
               end else begin
                  next_state.mode = MODE_HUNT;
               end
            end
         end
         MODE_ADDR: begin
            next_state.shift_chars = shifted;
            next_state.field_count = count_inc;
            if (count_inc == 2'd3) begin
               if (cur_state.direct_link || shifted == peer_addr) begin
                  next_state.mode        = MODE_LENGTH;
                  next_state.field_count = 2'd0;
                  next_state.bytes_left  = '0;
               end else begin
                  next_state.mode = MODE_HUNT;
               end
            end
         end
         MODE_LENGTH: begin
            next_state.bytes_left  = length_acc;
            next_state.field_count = count_inc;
            if (count_inc == 2'd3) begin
               if (length_acc != 16'd0 && length_acc <= MAX_PAYLOAD) begin
                  next_state.mode        = MODE_PAYLOAD;
                  next_state.field_count = 2'd0;
               end else begin
                  next_state.mode = MODE_HUNT;
               end
            end
         end
         MODE_PAYLOAD: begin
            next_state.bytes_left = cur_state.bytes_left - 16'd1;
            result.valid          = 1'b1;
            result.kind           = KIND_PAYLOAD;
            result.value          = rx_byte;
            result.last_byte      = (cur_state.bytes_left == 16'd1);
            if (cur_state.bytes_left == 16'd1) begin
               next_state.mode = MODE_FOOTER;
            end
         end
         MODE_FOOTER: begin
            // strength starts with a hundreds digit of zero or one
            if (digit inside {[8'd0:8'd1]}) begin
               next_state.strength_accum = digit;
               next_state.mode           = MODE_STRENGTH;
               next_state.field_count    = 2'd1;
            end else begin
               next_state.mode = MODE_HUNT;
            end
         end
         MODE_STRENGTH: begin
            if (digit inside {[8'd0:8'd9]}) begin
               next_state.strength_accum = strength_acc;
               next_state.field_count    = count_inc;
               if (count_inc == 2'd3) begin
                  next_state.mode = MODE_HUNT;
                  result.valid    = 1'b1;
                  result.kind     = KIND_STRENGTH;
                  result.value    = strength_acc;
               end
            end else begin
               next_state.mode = MODE_HUNT;
            end
         end
         default: begin
            // hunting, and the unused mode code behaves the same
            next_state.mode = MODE_HUNT;
            if (rx_byte == CHAR_R || rx_byte == CHAR_T) begin
               next_state.mode        = MODE_HEADER;
               next_state.direct_link = (rx_byte == CHAR_T);
               next_state.field_count = 2'd0;
               next_state.shift_chars = '0;
            end
         end
      endcase
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds modem bytes into radio_frame_rx_parser and checks each payload byte
// and signal strength update against a deframer model kept alongside, with
// random idle cycles on both channels and a new peer address for each run.
// ----------------------------------------------------------------------------
module testbench import rfrx_pkg::*;;

   localparam int CLK_PERIOD       = 10;
   localparam int RESET_CYCLES     = 8;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int SETTLE_CYCLES    = 4;
   localparam int BYTES_PER_RUN    = 450;
   localparam int NUM_RUNS         = 4;
   localparam int LONG_HOLD_AT     = 400;
   localparam int LONG_HOLD_CYCLES = 250;

   localparam logic [7:0] CH_B = HDR_BN[15:8];
   localparam logic [7:0] CH_N = HDR_BN[7:0];
   localparam logic [7:0] CH_X = 8'h58;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      logic       last_byte;
   } rx_item_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       typed_in;
      logic       kind;
      logic [7:0] value;
      logic       last_byte;
   } stim_row_type;

   localparam int NUM_DIRECTED = 23;
   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // ignored while hunting
      '{8'h00,              1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      // header that is not BN
      '{CHAR_R,             1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CH_X,               1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CH_N,               1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      // peer frame whose address misses the reset address by one character
      '{CHAR_R,             1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CH_B,               1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CH_N,               1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CHAR_ZERO + 8'd9,   1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CHAR_ZERO + 8'd9,   1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CHAR_ZERO + 8'd8,   1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      // direct link, any address, one byte of payload
      '{CHAR_T,             1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CH_B,               1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CH_N,               1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{8'hFF,              1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{8'h00,              1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{8'h80,              1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CHAR_ZERO,          1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CHAR_ZERO,          1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CHAR_ZERO + 8'd1,   1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{8'hFF,              1'b1, KIND_PAYLOAD,  8'hFF,        1'b1},
      // top strength value
      '{CHAR_ZERO + 8'd1,   1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CHAR_ZERO + 8'd9,   1'b0, KIND_PAYLOAD,  8'h00,        1'b0},
      '{CHAR_ZERO + 8'd9,   1'b1, KIND_STRENGTH, STRENGTH_MAX, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [7:0]  rsp_value;
   logic        rsp_last_byte;
   logic        csr_valid;
   logic        csr_ready;
   logic [23:0] csr_peer_addr_ascii;

   // deframer model state
   parse_mode_type pm_mode;
   logic           pm_direct;
   logic [1:0]     pm_count;
   logic [23:0]    pm_chars;
   logic [15:0]    pm_left;
   logic [7:0]     pm_strength;
   logic [23:0]    pm_peer;

   rx_item_type rx_items_due [$];
   int          error_count  = 0;
   int          results_seen = 0;
   int          bytes_fed    = 0;
   int          cycle_count  = 0;
   bit          calm_mode    = 1'b0;

   radio_frame_rx_parser u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_value           (rsp_value),
      .rsp_last_byte       (rsp_last_byte),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_peer_addr_ascii (csr_peer_addr_ascii)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [7:0] rand_byte();
      return 8'($urandom());
   endfunction

   function automatic logic [7:0] ascii_digit(input int v);
      return CHAR_ZERO + 8'(v % 10);
   endfunction

   task automatic deframe_byte(input logic [7:0] b, output logic produced,
                               output rx_item_type item);
      logic [7:0] digit;
      digit    = b - CHAR_ZERO;
      produced = 1'b0;
      item     = '0;
      case (pm_mode)
         MODE_HEADER: begin
            pm_chars = {pm_chars[15:0], b};
            pm_count = pm_count + 2'd1;
            if (pm_count == 2'd2) begin
               if (pm_chars == {8'h00, HDR_BN}) begin
                  pm_mode  = MODE_ADDR;
                  pm_count = '0;
                  pm_chars = '0;
               end else begin
                  pm_mode = MODE_HUNT;
               end
            end
         end
         MODE_ADDR: begin
            pm_chars = {pm_chars[15:0], b};
            pm_count = pm_count + 2'd1;
            if (pm_count == 2'd3) begin
               if (pm_direct || pm_chars == pm_peer) begin
                  pm_mode  = MODE_LENGTH;
                  pm_count = '0;
                  pm_left  = '0;
               end else begin
                  pm_mode = MODE_HUNT;
               end
            end
         end
         MODE_LENGTH: begin
            // digits are not checked, the sum wraps at 16 bits
            pm_left  = pm_left * 16'd10 + {8'h00, b} - {8'h00, CHAR_ZERO};
            pm_count = pm_count + 2'd1;
            if (pm_count == 2'd3) begin
               if (pm_left != '0 && pm_left <= MAX_PAYLOAD) begin
                  pm_mode  = MODE_PAYLOAD;
                  pm_count = '0;
               end else begin
                  pm_mode = MODE_HUNT;
               end
            end
         end
         MODE_PAYLOAD: begin
            pm_left  = pm_left - 16'd1;
            produced = 1'b1;
            item     = '{KIND_PAYLOAD, b, pm_left == '0};
            if (pm_left == '0) pm_mode = MODE_FOOTER;
         end
         MODE_FOOTER: begin
            if (digit <= 8'd1) begin
               pm_strength = digit;
               pm_mode     = MODE_STRENGTH;
               pm_count    = 2'd1;
            end else begin
               pm_mode = MODE_HUNT;
            end
         end
         MODE_STRENGTH: begin
            if (digit <= 8'd9) begin
               pm_strength = pm_strength * 8'd10 + digit;
               pm_count    = pm_count + 2'd1;
               if (pm_count == 2'd3) begin
                  pm_mode  = MODE_HUNT;
                  produced = 1'b1;
                  item     = '{KIND_STRENGTH, pm_strength, 1'b0};
               end
            end else begin
               pm_mode = MODE_HUNT;
            end
         end
         default: begin
            pm_mode = MODE_HUNT;
            if (b == CHAR_R || b == CHAR_T) begin
               pm_mode   = MODE_HEADER;
               pm_direct = (b == CHAR_T);
               pm_count  = '0;
               pm_chars  = '0;
            end
         end
      endcase
   endtask

   task automatic feed_byte(input logic [7:0] b, input logic typed_in,
                            input rx_item_type typed_item);
      int          gap;
      logic        produced;
      rx_item_type item;
      gap = calm_mode ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_ready !== 1'b1);
      deframe_byte(b, produced, item);
      if (typed_in) rx_items_due.push_back(typed_item);
      else if (produced) rx_items_due.push_back(item);
      bytes_fed++;
   endtask

   task automatic feed_plain(input logic [7:0] b);
      feed_byte(b, 1'b0, '0);
   endtask

   // mostly well-formed frames with random content, some broken, some noise
   task automatic feed_random_frame();
      int         roll;
      int         len;
      int         level;
      logic [7:0] opener;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         repeat ($urandom_range(1, 4)) feed_plain(rand_byte());
      end else begin
         opener = $urandom_range(0, 1) ? CHAR_R : CHAR_T;
         feed_plain(opener);
         if ($urandom_range(0, 99) < 4) begin
            feed_plain(rand_byte());
            feed_plain(rand_byte());
         end else begin
            feed_plain(CH_B);
            feed_plain(CH_N);
         end
         roll = $urandom_range(0, 99);
         for (int i = 2; i >= 0; i--) begin
            if (opener == CHAR_T || roll < 10) feed_plain(rand_byte());
            else if (roll < 15 && i == 0) feed_plain(pm_peer[7:0] ^ 8'h01);
            else feed_plain(pm_peer[8*i +: 8]);
         end
         roll = $urandom_range(0, 99);
         if (roll < 78) len = $urandom_range(1, 8);
         else if (roll < 86) len = $urandom_range(9, 128);
         else if (roll < 89) len = 128;
         else if (roll < 92) len = 0;
         else if (roll < 96) len = $urandom_range(129, 999);
         else len = -1;
         if (len < 0) begin
            repeat (3) feed_plain(rand_byte());
         end else begin
            feed_plain(ascii_digit(len / 100));
            feed_plain(ascii_digit(len / 10));
            feed_plain(ascii_digit(len));
            if (len >= 1 && len <= 128) repeat (len) feed_plain(rand_byte());
         end
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            if (roll < 5) level = 199;
            else if (roll < 10) level = 0;
            else level = $urandom_range(0, 199);
            feed_plain(ascii_digit(level / 100));
            feed_plain(ascii_digit(level / 10));
            if ($urandom_range(0, 19) == 0) feed_plain(rand_byte());
            else feed_plain(ascii_digit(level));
         end else if (roll < 85) begin
            feed_plain(rand_byte());
         end
         // otherwise the next opener falls on the footer
      end
   endtask

   task automatic write_peer(input logic [23:0] addr);
      csr_valid           <= 1'b1;
      csr_peer_addr_ascii <= addr;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      pm_peer = addr;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (rx_items_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [23:0] peer_plan [NUM_RUNS];
      rx_item_type want;
      pm_mode     = MODE_HUNT;
      pm_direct   = 1'b0;
      pm_count    = '0;
      pm_chars    = '0;
      pm_left     = '0;
      pm_strength = '0;
      pm_peer     = PEER_RESET;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_rx_byte         <= '0;
      csr_valid           <= 1'b0;
      csr_peer_addr_ascii <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         want = '{DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].value,
                  DIRECTED_ROWS[i].last_byte};
         feed_byte(DIRECTED_ROWS[i].rx_byte, DIRECTED_ROWS[i].typed_in, want);
      end

      peer_plan = '{24'h000000, 24'hFFFFFF, 24'($urandom()), PEER_RESET};
      for (int p = 0; p < NUM_RUNS; p++) begin
         settle();
         write_peer(peer_plan[p]);
         // one run without idle cycles on either side
         calm_mode = (p == 2);
         bytes_fed = 0;
         while (bytes_fed < BYTES_PER_RUN) feed_random_frame();
      end
      calm_mode = 1'b0;
      settle();

      if (error_count == 0 && rx_items_due.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // result side: check each transaction, then draw the next hold-off
   initial begin
      int          hold;
      rx_item_type want;
      hold = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            results_seen++;
            if (rx_items_due.size() == 0) begin
               error_count++;
               $display(
                  "%0t: unexpected result: expected none, actual kind %0d value %0d last %0d",
                  $time, rsp_kind, rsp_value, rsp_last_byte);
            end else begin
               want = rx_items_due.pop_front();
               if (rsp_kind !== want.kind) begin
                  error_count++;
                  $display("%0t: kind mismatch: expected %0d, actual %0d",
                           $time, want.kind, rsp_kind);
               end
               if (rsp_value !== want.value) begin
                  error_count++;
                  $display("%0t: value mismatch: expected %0d, actual %0d",
                           $time, want.value, rsp_value);
               end
               if (rsp_last_byte !== want.last_byte) begin
                  error_count++;
                  $display("%0t: last_byte mismatch: expected %0d, actual %0d",
                           $time, want.last_byte, rsp_last_byte);
               end
            end
            hold = calm_mode ? 0 : $urandom_range(0, 3);
            // long stall so the result register fills and input backs up
            if (results_seen == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: done, errors");
      $finish;
   end

endmodule
